### hw/rtl/drq_pkg.sv
// ----------------------------------------------------------------------------
// drq_pkg
// Shared sizes and codes for the earliest-deadline-first ready queue.
// ----------------------------------------------------------------------------
package drq_pkg;

  localparam int DRQ_DEPTH     = 16;
  localparam int DRQ_KEY_WIDTH = 32;
  localparam int DRQ_HANDLE_W  = 8;
  localparam int DRQ_STATUS_W  = 2;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  localparam logic [DRQ_STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [DRQ_STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [DRQ_STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

### hw/rtl/deadline_ready_queue.sv
// ----------------------------------------------------------------------------
// deadline_ready_queue
// Earliest-deadline-first ready queue: sorted insert and head extract.
// ----------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                     tuser
// in_      in   task_id, deadline                      command
// out_     out  out_task_id, out_deadline, queue_count status
//
// Entries sit in one RAM, largest key at address 0, head at count-1.
// Insert: walks down from the head while held keys are smaller, then writes
// the new entry; one RAM read and one write per cycle shift the walk.
// Extract: one head read. A refused or empty item goes straight to its result.
// Reset empties the queue at once. A new item is taken while a result
// waits on out_; the next result holds until that transfer.
// ----------------------------------------------------------------------------
module deadline_ready_queue
  import drq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DRQ_DEPTH,
  parameter int KEY_WIDTH   = DRQ_KEY_WIDTH,
  localparam int CW     = $clog2(QUEUE_DEPTH + 1),
  localparam int IN_DW  = ((DRQ_HANDLE_W + KEY_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW = ((DRQ_HANDLE_W + KEY_WIDTH + CW + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_DW-1:0]        in_tdata,   // task_id, deadline
  input  logic                    in_tuser,   // command
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_DW-1:0]       out_tdata,  // out_task_id, out_deadline, queue_count
  output logic [DRQ_STATUS_W-1:0] out_tuser   // status
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int HW = DRQ_HANDLE_W;
  localparam int EW = HW + KEY_WIDTH;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_WALK    = 3'd1;
  localparam logic [2:0] S_PLACE   = 3'd2;
  localparam logic [2:0] S_EXTRACT = 3'd3;
  localparam logic [2:0] S_FINISH  = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [AW-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [KEY_WIDTH-1:0]    key_r, key_nxt;
  logic [HW-1:0]           id_r, id_nxt;
  logic [DRQ_STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [HW-1:0]           res_id_r, res_id_nxt;
  logic [KEY_WIDTH-1:0]    res_key_r, res_key_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [DRQ_STATUS_W-1:0] out_status_r;
  logic [HW-1:0]           out_id_r;
  logic [KEY_WIDTH-1:0]    out_key_r;
  logic [CW-1:0]           out_count_r;
  logic                    out_load;

  logic                    ram_wr_en, ram_rd_en;
  logic [AW-1:0]           ram_wr_addr, ram_rd_addr;
  logic [EW-1:0]           ram_wr_data, ram_rd_data;
  logic [KEY_WIDTH-1:0]    rd_key;
  logic [CW-1:0]           count_m1;
  logic                    in_xfer;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign count_m1  = count_r - CW'(1);
  assign rd_key    = ram_rd_data[KEY_WIDTH-1:0];
  assign out_load  = (state_r == S_FINISH) && (!out_valid_r || out_tready);

  drq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_ptr_nxt     = rd_ptr_r;
    key_nxt        = key_r;
    id_nxt         = id_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_key_nxt    = res_key_r;
    out_valid_nxt  = out_valid_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = rd_ptr_r + AW'(1);
    ram_wr_data    = ram_rd_data;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = count_m1[AW-1:0];

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          key_nxt        = in_tdata[HW+KEY_WIDTH-1:HW];
          id_nxt         = in_tdata[HW-1:0];
          res_status_nxt = ST_DONE;
          res_id_nxt     = '0;
          res_key_nxt    = '0;
          rd_ptr_nxt     = count_m1[AW-1:0];
          if (in_tuser == CMD_INSERT) begin
            if (count_r == CW'(QUEUE_DEPTH)) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_FINISH;
            end else if (count_r == '0) begin
              state_nxt = S_PLACE;
            end else begin
              ram_rd_en = 1'b1;
              state_nxt = S_WALK;
            end
          end else begin
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_FINISH;
            end else begin
              ram_rd_en = 1'b1;
              state_nxt = S_EXTRACT;
            end
          end
        end
      end
      S_WALK: begin
        ram_wr_en = 1'b1;
        if (rd_key < key_r) begin
          if (rd_ptr_r == '0) begin
            state_nxt = S_PLACE;
          end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = rd_ptr_r - AW'(1);
            rd_ptr_nxt  = rd_ptr_r - AW'(1);
          end
        end else begin
          ram_wr_data = {id_r, key_r};
          count_nxt   = count_r + CW'(1);
          state_nxt   = S_FINISH;
        end
      end
      S_PLACE: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = '0;
        ram_wr_data = {id_r, key_r};
        count_nxt   = count_r + CW'(1);
        state_nxt   = S_FINISH;
      end
      S_EXTRACT: begin
        res_id_nxt  = ram_rd_data[EW-1:KEY_WIDTH];
        res_key_nxt = rd_key;
        count_nxt   = count_m1;
        state_nxt   = S_FINISH;
      end
      S_FINISH: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_ptr_r     <= rd_ptr_nxt;
    key_r        <= key_nxt;
    id_r         <= id_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_key_r    <= res_key_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_key_r    <= res_key_r;
      out_count_r  <= count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_DW'({out_count_r, out_key_r, out_id_r});

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_extract_dec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXTRACT |=> count_r == $past(count_r) - CW'(1))
    else $error("extract did not drop one entry");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> {1'b0, rd_ptr_r} < (AW+1)'(count_r))
    else $error("walk pointer outside held entries");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && res_status_r == ST_FULL |-> count_r == CW'(QUEUE_DEPTH))
    else $error("full status with room left");
`endif

endmodule

### hw/rtl/drq_ram.sv
// ----------------------------------------------------------------------------
// drq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module drq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### tb/sv/tb_deadline_ready_queue.sv
// ----------------------------------------------------------------------------
// tb_deadline_ready_queue
// Self-checking bench for the earliest-deadline-first ready queue. A sorted
// copy of the queue predicts each result: inserts ahead of equal keys,
// head extracts, refusals on a full queue and empty extracts. Stimulus is a
// short directed list, then random fill-heavy, balanced and drain-heavy
// stretches under four idle and stall profiles on both stream channels.
// ----------------------------------------------------------------------------
module tb_deadline_ready_queue
  import drq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_DW        = 40;
  localparam int OUT_DW       = 48;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 64;
  localparam int CHUNK_ITEMS  = 40;
  localparam int CHUNKS       = 10;

  typedef struct packed {
    logic [DRQ_STATUS_W-1:0]  status;
    logic [DRQ_HANDLE_W-1:0]  task_id;
    logic [DRQ_KEY_WIDTH-1:0] deadline;
    logic [4:0]               count;
  } queue_result_t;

  class ready_queue_model;
    logic [DRQ_KEY_WIDTH-1:0] keys[DRQ_DEPTH];
    logic [DRQ_HANDLE_W-1:0]  handles[DRQ_DEPTH];
    int unsigned              held = 0;
    queue_result_t            due_results[$];
    int unsigned              errors = 0;
    int unsigned              inserts = 0;
    int unsigned              refused = 0;
    int unsigned              extracts = 0;
    int unsigned              empties = 0;

    function void take_command(logic cmd, logic [DRQ_HANDLE_W-1:0] id,
                               logic [DRQ_KEY_WIDTH-1:0] key);
      queue_result_t res;
      int unsigned   pos;
      res = '0;
      res.status = ST_DONE;
      if (cmd == CMD_INSERT) begin
        inserts++;
        if (held >= DRQ_DEPTH) begin
          res.status = ST_FULL;
          refused++;
        end else begin
          pos = 0;
          while (pos < held && key > keys[pos]) pos++;
          for (int i = held; i > pos; i--) begin
            keys[i]    = keys[i-1];
            handles[i] = handles[i-1];
          end
          keys[pos]    = key;
          handles[pos] = id;
          held++;
        end
      end else begin
        extracts++;
        if (held == 0) begin
          res.status = ST_EMPTY;
          empties++;
        end else begin
          res.task_id  = handles[0];
          res.deadline = keys[0];
          for (int i = 1; i < held; i++) begin
            keys[i-1]    = keys[i];
            handles[i-1] = handles[i];
          end
          held--;
        end
      end
      res.count = held[4:0];
      due_results.push_back(res);
    endfunction

    function void report(string field, logic [31:0] exp_val, logic [31:0] got_val);
      if (exp_val !== got_val) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_val, got_val);
      end
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t exp_res;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %0h", $time, got);
        return;
      end
      exp_res = due_results.pop_front();
      report("status", 32'(exp_res.status), 32'(got.status));
      report("task_id", 32'(exp_res.task_id), 32'(got.task_id));
      report("deadline", exp_res.deadline, got.deadline);
      report("queue_count", 32'(exp_res.count), 32'(got.count));
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_DW-1:0]        in_tdata = '0;
  logic                    in_tuser = CMD_INSERT;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DW-1:0]       out_tdata;
  logic [DRQ_STATUS_W-1:0] out_tuser;

  int unsigned      snd_idle_pct = 0;
  int unsigned      rcv_stall_pct = 0;
  int unsigned      cycle_count = 0;
  ready_queue_model model = new;

  deadline_ready_queue DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, model.due_results.size());
    $display("FAIL deadline_ready_queue");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      model.check_result({out_tuser, out_tdata[7:0], out_tdata[39:8], out_tdata[44:40]});
    end
    out_tready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  function automatic logic [DRQ_KEY_WIDTH-1:0] random_deadline();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2, 3:    return DRQ_KEY_WIDTH'($urandom_range(7));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic cmd, input logic [DRQ_HANDLE_W-1:0] id,
                           input logic [DRQ_KEY_WIDTH-1:0] key);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {key, id};
    do @(posedge clk); while (!in_tready);
    model.take_command(cmd, id, key);
  endtask

  initial begin
    int unsigned phase_idle[4];
    int unsigned phase_stall[4];
    int unsigned insert_pct;
    logic        quiet;
    logic        cmd;

    phase_idle  = '{0, 75, 0, 28};
    phase_stall = '{0, 0, 75, 28};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_item(CMD_EXTRACT, 8'hFF, 32'hFFFF_FFFF);
    send_item(CMD_INSERT, 8'h00, 32'hFFFF_FFFF);
    send_item(CMD_INSERT, 8'hFF, 32'h0000_0000);
    send_item(CMD_INSERT, 8'hA5, 32'h8000_0000);
    send_item(CMD_INSERT, 8'h5A, 32'h8000_0000);
    send_item(CMD_INSERT, 8'h01, 32'h0000_0000);
    send_item(CMD_INSERT, 8'h02, 32'hFFFF_FFFF);
    repeat (7) send_item(CMD_EXTRACT, 8'h00, 32'h0000_0000);

    for (int phase = 0; phase < 4; phase++) begin
      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
        quiet         = ($urandom_range(4) == 0);
        snd_idle_pct  = quiet ? 0 : phase_idle[phase];
        rcv_stall_pct = quiet ? 0 : phase_stall[phase];
        case ($urandom_range(2))
          0:       insert_pct = 85;
          1:       insert_pct = 50;
          default: insert_pct = 15;
        endcase
        if (chunk == 0) insert_pct = 90;
        repeat (CHUNK_ITEMS) begin
          cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_EXTRACT;
          send_item(cmd, DRQ_HANDLE_W'($urandom_range(255)), random_deadline());
        end
      end
    end
    in_tvalid <= 1'b0;

    while (model.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d inserts (%0d refused on a full queue) and %0d extracts",
             model.inserts, model.refused, model.extracts);
    $display("%0d extracts hit an empty queue; %0d mismatches", model.empties, model.errors);
    if (model.errors == 0) begin
      $display("PASS deadline_ready_queue");
    end else begin
      $display("FAIL deadline_ready_queue");
    end
    $finish;
  end

endmodule
